[rtl/core/tsjr_pkg.sv]
// Shared types, constants and saturating Q arithmetic for the SE3 Jacobian row block.
// No dependencies; the divider, the row block and the checker import this package.
`default_nettype none

package tsjr_pkg;

	// signed Q value as held on every datapath bus
	typedef logic signed [31:0] q_t;

	// one pixel transaction
	typedef struct packed {
		q_t pix_u;
		q_t pix_v;
		q_t grad_u;
		q_t grad_v;
		q_t inv_depth;
		q_t inv_depth_du;
		q_t inv_depth_dv;
	} pix_t;

	// one Jacobian row transaction
	typedef struct packed {
		q_t   jac_tx;
		q_t   jac_ty;
		q_t   jac_tz;
		q_t   jac_rx;
		q_t   jac_ry;
		q_t   jac_rz;
		logic singular;
	} jrow_t;

	// configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_FOCAL_U  = 3'd0;
	localparam cfg_idx_t CFG_FOCAL_V  = 3'd1;
	localparam cfg_idx_t CFG_CENTER_U = 3'd2;
	localparam cfg_idx_t CFG_CENTER_V = 3'd3;
	localparam cfg_idx_t CFG_TRANS_1  = 3'd4;
	localparam cfg_idx_t CFG_TRANS_2  = 3'd5;
	localparam cfg_idx_t CFG_TRANS_3  = 3'd6;

	localparam q_t Q_MAX = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN = 32'sh8000_0000;

	// divider: one quotient bit per stage, plus entry and exit registers
	localparam int DIV_ITER = 32;
	localparam int DIV_LAT  = DIV_ITER + 2;

	// clamp a wide exact result into Q, flag when the clamp bites
	function automatic q_t q_sat(input logic signed [63:0] x, inout logic sat);
		q_t r;
		if (x > 64'sd2147483647) begin
			sat = 1'b1;
			r   = Q_MAX;
		end else if (x < -64'sd2147483648) begin
			sat = 1'b1;
			r   = Q_MIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic q_t q_add(input q_t a, input q_t b, inout logic sat);
		return q_sat(64'(a) + 64'(b), sat);
	endfunction

	function automatic q_t q_sub(input q_t a, input q_t b, inout logic sat);
		return q_sat(64'(a) - 64'(b), sat);
	endfunction

	// 0 - x, so the most negative value saturates
	function automatic q_t q_neg(input q_t a, inout logic sat);
		return q_sat(-64'(a), sat);
	endfunction

endpackage

`default_nettype wire

[rtl/core/tsjr_stream_if.sv]
// Valid/ready stream interface carrying one payload struct per transaction.
// Payload type is set at instantiation (tsjr_pkg::pix_t or tsjr_pkg::jrow_t).
`default_nettype none

interface tsjr_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/tsjr_div.sv]
// Pipelined signed Q divider: quo = (num * 2^FRAC_BITS) / den, truncated, saturated.
// Restoring division, one quotient bit per stage; entry, iteration and exit registers advance only on en.
`default_nettype none

module tsjr_div
	import tsjr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire  clk,
	input  wire  en,
	input  wire q_t num,
	input  wire q_t den,
	output q_t   quo,
	output logic sat
);

	typedef struct packed {
		logic neg;   // quotient sign
		logic zero;  // zero divisor
		logic nneg;  // numerator negative
		logic ovf;   // magnitude at least 2^32
	} dflag_t;

	logic [31:0] rem_s [DIV_ITER+1];
	logic [31:0] lo_s  [DIV_ITER+1];
	logic [31:0] q_s   [DIV_ITER+1];
	logic [31:0] dv_s  [DIV_ITER+1];
	dflag_t      fl_s  [DIV_ITER+1];

	// entry: magnitudes, shifted numerator and overflow test
	logic signed [32:0] nx;
	logic signed [32:0] dx;
	logic [32:0]        na;
	logic [31:0]        nb;
	logic [63:0]        num_w;
	dflag_t             fl_in;

	always_comb begin
		nx          = 33'(num);
		dx          = 33'(den);
		na          = nx[32] ? 33'(-nx) : 33'(nx);
		nb          = dx[32] ? 32'(-dx) : 32'(dx);
		num_w       = 64'(na) << FRAC_BITS;
		fl_in.neg   = num[31] ^ den[31];
		fl_in.zero  = (den == '0);
		fl_in.nneg  = num[31];
		fl_in.ovf   = (num_w[63:32] >= nb);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_w[63:32];
			lo_s[0]  <= num_w[31:0];
			q_s[0]   <= '0;
			dv_s[0]  <= nb;
			fl_s[0]  <= fl_in;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < DIV_ITER; k++) begin : g_iter
		logic [32:0] t;
		logic        ge;
		always_comb begin
			t  = {rem_s[k], lo_s[k][31]};
			ge = (t >= {1'b0, dv_s[k]});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? 32'(t - {1'b0, dv_s[k]}) : t[31:0];
				lo_s[k+1]  <= {lo_s[k][30:0], 1'b0};
				q_s[k+1]   <= {q_s[k][30:0], ge};
				dv_s[k+1]  <= dv_s[k];
				fl_s[k+1]  <= fl_s[k];
			end
		end
	end

	// exit: sign, zero-divisor and saturation
	q_t          quo_c;
	logic        sat_c;
	logic [31:0] qm;
	dflag_t      fo;

	always_comb begin
		qm    = q_s[DIV_ITER];
		fo    = fl_s[DIV_ITER];
		sat_c = 1'b0;
		quo_c = qm;
		if (fo.zero) begin
			sat_c = 1'b1;
			quo_c = fo.nneg ? Q_MIN : Q_MAX;
		end else if (fo.ovf) begin
			sat_c = 1'b1;
			quo_c = fo.neg ? Q_MIN : Q_MAX;
		end else if (!fo.neg) begin
			if (qm[31]) begin
				sat_c = 1'b1;
				quo_c = Q_MAX;
			end
		end else begin
			if (qm > 32'h8000_0000) begin
				sat_c = 1'b1;
				quo_c = Q_MIN;
			end else begin
				quo_c = -qm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= quo_c;
			sat <= sat_c;
		end
	end

endmodule

`default_nettype wire

[rtl/core/texture_se3_jacobian_row.sv]
// SE3 Jacobian row for textured-model tracking, one pixel per cycle while the skid stage is empty.
// The path from pixel acceptance to the output row runs through two 34-stage dividers
// in series (coordinates and s0 reciprocal, then s reciprocal).
// Takes one transaction per cycle while the skid stage is empty; an output register
// and a skid stage decouple the sides. Reset clears all valid bits and loads register reset values.
`default_nettype none

module texture_se3_jacobian_row
	import tsjr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_wen,
	input  wire cfg_idx_t  cfg_index,
	input  wire [31:0]     cfg_wdata,
	tsjr_stream_if.sink    pixel,
	tsjr_stream_if.source  jrow
);

	localparam q_t ONE     = q_t'(1 << FRAC_BITS);
	localparam q_t NEG_ONE = q_t'(-(1 << FRAC_BITS));

	// floor(a*b / 2^FRAC_BITS), clamped
	function automatic q_t q_mul(input q_t a, input q_t b, inout logic sat);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return q_sat(p >>> FRAC_BITS, sat);
	endfunction

	// everything one pixel carries down the pipe; unused fields trim away
	typedef struct packed {
		logic vld;
		logic sat;
		q_t   pu, pv, gu, gv, zi, ziu, ziv;
		q_t   du, dv, t3zi, d1, d2, z1, z2, s0;
		q_t   xr, yr, s0i;
		q_t   ta1, ta2, xt, yt, nyr;
		q_t   a1, a2, xw, yw;
		q_t   s1, s2, na1, na2, j13, j23, j14, xrxw, yryw, j25;
		q_t   den1, l11, j15, j24, l12, l21;
		q_t   den, s;
		q_t   fus, fvs, iuf, ivf;
		q_t   m1, m2, m3, m4, vx, vy;
		q_t   vxz, vyz, p3a, p3b, p4a, p4b, p5a, p5b;
		q_t   p2a, p2b, r3, r4, r5, r2;
	} pipe_t;

	// configuration registers
	logic [30:0] focal_u_q, focal_v_q;
	q_t          center_u_q, center_v_q, trans_1_q, trans_2_q, trans_3_q;
	q_t          fu, fv;

	assign fu = q_t'({1'b0, focal_u_q});
	assign fv = q_t'({1'b0, focal_v_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_u_q  <= 31'(1 << FRAC_BITS);
			focal_v_q  <= 31'(1 << FRAC_BITS);
			center_u_q <= '0;
			center_v_q <= '0;
			trans_1_q  <= '0;
			trans_2_q  <= '0;
			trans_3_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_FOCAL_U:  focal_u_q  <= cfg_wdata[30:0];
				CFG_FOCAL_V:  focal_v_q  <= cfg_wdata[30:0];
				CFG_CENTER_U: center_u_q <= cfg_wdata;
				CFG_CENTER_V: center_v_q <= cfg_wdata;
				CFG_TRANS_1:  trans_1_q  <= cfg_wdata;
				CFG_TRANS_2:  trans_2_q  <= cfg_wdata;
				CFG_TRANS_3:  trans_3_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advance: frozen only while the skid stage holds a row
	logic en;
	logic skid_vld_q, out_vld_q;
	jrow_t skid_q, out_q;

	assign en          = !skid_vld_q;
	assign pixel.ready = en;

	pipe_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7;
	pipe_t p_s8, p_s9, p_s10, p_s11, p_s12, p_s13, p_s14;
	pipe_t dl1_s [DIV_LAT];
	pipe_t dl2_s [DIV_LAT];
	pipe_t c1, c2, ca, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12, c13, c14;

	q_t   xr_q, yr_q, s0i_q, s_q;
	logic xr_sat, yr_sat, s0i_sat, s_sat;

	// input capture
	always_comb begin
		c1     = '0;
		c1.vld = pixel.valid;
		c1.pu  = pixel.data.pix_u;
		c1.pv  = pixel.data.pix_v;
		c1.gu  = pixel.data.grad_u;
		c1.gv  = pixel.data.grad_v;
		c1.zi  = pixel.data.inv_depth;
		c1.ziu = pixel.data.inv_depth_du;
		c1.ziv = pixel.data.inv_depth_dv;
	end

	// centring and depth products
	always_comb begin
		c2      = p_s1;
		c2.du   = q_sub(p_s1.pu, center_u_q, c2.sat);
		c2.dv   = q_sub(p_s1.pv, center_v_q, c2.sat);
		c2.t3zi = q_mul(trans_3_q, p_s1.zi, c2.sat);
		c2.d1   = q_mul(fu, p_s1.ziu, c2.sat);
		c2.d2   = q_mul(fv, p_s1.ziv, c2.sat);
		c2.z1   = q_mul(p_s1.zi, trans_1_q, c2.sat);
		c2.z2   = q_mul(p_s1.zi, trans_2_q, c2.sat);
	end

	// first warp scale, feeds the first divider bank
	always_comb begin
		ca    = p_s2;
		ca.s0 = q_sub(ONE, p_s2.t3zi, ca.sat);
	end

	tsjr_div #(.FRAC_BITS(FRAC_BITS)) u_div_xr (
		.clk(clk), .en(en), .num(p_s2.du), .den(fu), .quo(xr_q), .sat(xr_sat)
	);
	tsjr_div #(.FRAC_BITS(FRAC_BITS)) u_div_yr (
		.clk(clk), .en(en), .num(p_s2.dv), .den(fv), .quo(yr_q), .sat(yr_sat)
	);
	tsjr_div #(.FRAC_BITS(FRAC_BITS)) u_div_s0i (
		.clk(clk), .en(en), .num(ONE), .den(ca.s0), .quo(s0i_q), .sat(s0i_sat)
	);

	// normalised point, translation products
	always_comb begin
		c3     = dl1_s[DIV_LAT-1];
		c3.sat = c3.sat | xr_sat | yr_sat | s0i_sat;
		c3.xr  = xr_q;
		c3.yr  = yr_q;
		c3.s0i = s0i_q;
		c3.ta1 = q_mul(trans_3_q, xr_q, c3.sat);
		c3.ta2 = q_mul(trans_3_q, yr_q, c3.sat);
		c3.xt  = q_sub(xr_q, c3.z1, c3.sat);
		c3.yt  = q_sub(yr_q, c3.z2, c3.sat);
		c3.nyr = q_neg(yr_q, c3.sat);
	end

	// a terms and warped point
	always_comb begin
		c4    = p_s3;
		c4.a1 = q_sub(p_s3.ta1, trans_1_q, c4.sat);
		c4.a2 = q_sub(p_s3.ta2, trans_2_q, c4.sat);
		c4.xw = q_mul(p_s3.xt, p_s3.s0i, c4.sat);
		c4.yw = q_mul(p_s3.yt, p_s3.s0i, c4.sat);
	end

	// s1, s2 and point Jacobian products
	always_comb begin
		c5      = p_s4;
		c5.s1   = q_mul(p_s4.a1, p_s4.d1, c5.sat);
		c5.s2   = q_mul(p_s4.a2, p_s4.d2, c5.sat);
		c5.na1  = q_neg(p_s4.a1, c5.sat);
		c5.na2  = q_neg(p_s4.a2, c5.sat);
		c5.j13  = q_neg(p_s4.xw, c5.sat);
		c5.j23  = q_neg(p_s4.yw, c5.sat);
		c5.j14  = q_mul(p_s4.nyr, p_s4.xw, c5.sat);
		c5.xrxw = q_mul(p_s4.xr, p_s4.xw, c5.sat);
		c5.yryw = q_mul(p_s4.yr, p_s4.yw, c5.sat);
		c5.j25  = q_mul(p_s4.xr, p_s4.yw, c5.sat);
	end

	// correction matrix; den1 doubles as l22
	always_comb begin
		c6      = p_s5;
		c6.den1 = q_add(p_s5.s0, p_s5.s1, c6.sat);
		c6.l11  = q_add(p_s5.s0, p_s5.s2, c6.sat);
		c6.j15  = q_add(ONE, p_s5.xrxw, c6.sat);
		c6.j24  = q_sub(NEG_ONE, p_s5.yryw, c6.sat);
		c6.l12  = q_mul(p_s5.na1, p_s5.d2, c6.sat);
		c6.l21  = q_mul(p_s5.na2, p_s5.d1, c6.sat);
	end

	always_comb begin
		c7     = p_s6;
		c7.den = q_add(p_s6.den1, p_s6.s2, c7.sat);
	end

	tsjr_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
		.clk(clk), .en(en), .num(ONE), .den(p_s7.den), .quo(s_q), .sat(s_sat)
	);

	// scaled focal lengths
	always_comb begin
		c8     = dl2_s[DIV_LAT-1];
		c8.sat = c8.sat | s_sat;
		c8.s   = s_q;
		c8.fus = q_mul(fu, s_q, c8.sat);
		c8.fvs = q_mul(fv, s_q, c8.sat);
	end

	always_comb begin
		c9     = p_s8;
		c9.iuf = q_mul(p_s8.gu, p_s8.fus, c9.sat);
		c9.ivf = q_mul(p_s8.gv, p_s8.fvs, c9.sat);
	end

	always_comb begin
		c10    = p_s9;
		c10.m1 = q_mul(p_s9.iuf, p_s9.l11, c10.sat);
		c10.m2 = q_mul(p_s9.ivf, p_s9.l21, c10.sat);
		c10.m3 = q_mul(p_s9.iuf, p_s9.l12, c10.sat);
		c10.m4 = q_mul(p_s9.ivf, p_s9.den1, c10.sat);
	end

	// gradient velocity
	always_comb begin
		c11    = p_s10;
		c11.vx = q_add(p_s10.m1, p_s10.m2, c11.sat);
		c11.vy = q_add(p_s10.m3, p_s10.m4, c11.sat);
	end

	// projection products
	always_comb begin
		c12     = p_s11;
		c12.vxz = q_mul(p_s11.vx, p_s11.zi, c12.sat);
		c12.vyz = q_mul(p_s11.vy, p_s11.zi, c12.sat);
		c12.p3a = q_mul(p_s11.vx, p_s11.j14, c12.sat);
		c12.p3b = q_mul(p_s11.vy, p_s11.j24, c12.sat);
		c12.p4a = q_mul(p_s11.vx, p_s11.j15, c12.sat);
		c12.p4b = q_mul(p_s11.vy, p_s11.j25, c12.sat);
		c12.p5a = q_mul(p_s11.vx, p_s11.nyr, c12.sat);
		c12.p5b = q_mul(p_s11.vy, p_s11.xr, c12.sat);
	end

	always_comb begin
		c13     = p_s12;
		c13.p2a = q_mul(p_s12.vxz, p_s12.j13, c13.sat);
		c13.p2b = q_mul(p_s12.vyz, p_s12.j23, c13.sat);
		c13.r3  = q_add(p_s12.p3a, p_s12.p3b, c13.sat);
		c13.r4  = q_add(p_s12.p4a, p_s12.p4b, c13.sat);
		c13.r5  = q_add(p_s12.p5a, p_s12.p5b, c13.sat);
	end

	always_comb begin
		c14    = p_s13;
		c14.r2 = q_add(p_s13.p2a, p_s13.p2b, c14.sat);
	end

	// pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1  <= '0;
			p_s2  <= '0;
			p_s3  <= '0;
			p_s4  <= '0;
			p_s5  <= '0;
			p_s6  <= '0;
			p_s7  <= '0;
			p_s8  <= '0;
			p_s9  <= '0;
			p_s10 <= '0;
			p_s11 <= '0;
			p_s12 <= '0;
			p_s13 <= '0;
			p_s14 <= '0;
			for (int k = 0; k < DIV_LAT; k++) begin
				dl1_s[k] <= '0;
				dl2_s[k] <= '0;
			end
		end else if (en) begin
			p_s1     <= c1;
			p_s2     <= c2;
			dl1_s[0] <= ca;
			p_s3     <= c3;
			p_s4     <= c4;
			p_s5     <= c5;
			p_s6     <= c6;
			p_s7     <= c7;
			dl2_s[0] <= p_s7;
			p_s8     <= c8;
			p_s9     <= c9;
			p_s10    <= c10;
			p_s11    <= c11;
			p_s12    <= c12;
			p_s13    <= c13;
			p_s14    <= c14;
			for (int k = 1; k < DIV_LAT; k++) begin
				dl1_s[k] <= dl1_s[k-1];
				dl2_s[k] <= dl2_s[k-1];
			end
		end
	end

	// result row from the last stage
	jrow_t row_c;
	always_comb begin
		row_c.jac_tx   = p_s14.vxz;
		row_c.jac_ty   = p_s14.vyz;
		row_c.jac_tz   = p_s14.r2;
		row_c.jac_rx   = p_s14.r3;
		row_c.jac_ry   = p_s14.r4;
		row_c.jac_rz   = p_s14.r5;
		row_c.singular = p_s14.sat;
	end

	// output register with skid stage
	logic take;
	assign take = out_vld_q && jrow.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (p_s14.vld) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (p_s14.vld) begin
			if (!out_vld_q || take) begin
				out_q <= row_c;
			end else begin
				skid_q <= row_c;
			end
		end
	end

	assign jrow.valid = out_vld_q;
	assign jrow.data  = out_q;

endmodule

`default_nettype wire

[rtl/core/tsjr_checker.sv]
// Port-level checks on the SE3 Jacobian row block, attached by bind.
// Depends on tsjr_pkg and texture_se3_jacobian_row.
`default_nettype none

module tsjr_checker
	import tsjr_pkg::*;
(
	input wire   clk,
	input wire   arst_n,
	input wire   in_valid,
	input wire   in_ready,
	input wire   out_valid,
	input wire   out_ready,
	input wire jrow_t out_data
);

	// a stalled row stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("row dropped while stalled");

	// and does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("row changed while stalled");

	// input back-pressure only follows an output stall
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input throttled without output stall");

	// while throttled a row is always on offer
	a_throttle_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input throttled with no row pending");

endmodule

bind texture_se3_jacobian_row tsjr_checker u_tsjr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (jrow.valid),
	.out_ready (jrow.ready),
	.out_data  (jrow.data)
);

`default_nettype wire
